>>> hw/rtl/fpsq_pkg.sv
package fpsq_pkg;

   // Operand and result widths.
   localparam int unsigned MAG_W  = 64;
   localparam int unsigned OUT_W  = 49;

   // Root bits produced by the recurrence, one per step.
   localparam int unsigned ROOT_W = 48;

   // Width of the partial remainder after the next two radicand bits are shifted in.
   localparam int unsigned REM_W  = ROOT_W + 3;

   // Number of recurrence steps, one per pipeline stage.
   localparam int unsigned STEPS  = ROOT_W;

   // Work carried from one recurrence stage to the next.
   typedef struct packed {
      logic              neg;
      logic [MAG_W-1:0]  mag;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } fpsq_stage_type;

endpackage

>>> hw/rtl/fixed_point_square_root_q32_32.sv
// Signed Q32.32 square root, one operand per transfer.
// The request channel carries req_value (signed Q32.32); a transfer happens at a rising
// clock edge with req_valid high and req_stall low. The response channel carries
// rsp_root (signed Q16.32, 49 bits), the root of |req_value|, negated for a negative
// operand; the downstream side holds rsp_stall high to hold a response.
// The csr channel writes round_enable (reset value 1): when set, the root is rounded
// to nearest, otherwise it is truncated. Write it only while the block is idle.
// One stage forms the magnitude, 48 stages each run one restoring step and retire
// one root bit, one stage rounds and one stage negates. Throughput is one transfer
// per cycle while no response is held. The whole pipeline moves as one: when a
// response is held by rsp_stall, every stage holds and req_stall is raised, so no
// item is lost or repeated. The pipeline keeps accepting while the output register
// is empty or being drained.
// Synchronous reset empties every stage and sets round_enable to 1.
module fixed_point_square_root_q32_32
   import fpsq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [MAG_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_root,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_round_enable
);

   logic           advance;
   logic           round_enable_ff;
   logic           valid  [0:STEPS];
   fpsq_stage_type stage  [0:STEPS];

   // The pipeline moves unless a finished response is waiting and held downstream.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // The configuration register accepts a write on every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         round_enable_ff <= csr_round_enable;
      end
   end

   fpsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_value  (req_value),
      .out_valid (valid[0]),
      .out_stage (stage[0])
   );

   // One restoring step per stage, most significant root bit first.
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      fpsq_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid[g]),
         .in_stage  (stage[g]),
         .out_valid (valid[g+1]),
         .out_stage (stage[g+1])
      );
   end

   fpsq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .round_enable (round_enable_ff),
      .in_valid     (valid[STEPS]),
      .in_stage     (stage[STEPS]),
      .out_valid    (rsp_valid),
      .out_root     (rsp_root)
   );

   // A response appears only after the last recurrence stage held an item that then
   // passed through the round and negate stages.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(valid[STEPS], 2))
      else $error("response without a finished item");

   // Requests are refused only while a response is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |-> (rsp_valid && rsp_stall))
      else $error("request refused without a held response");

   // A held response keeps the pipeline frozen, as seen at the last recurrence stage's valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid[STEPS]))
      else $error("pipeline moved while response held");

endmodule

>>> hw/rtl/fpsq_front.sv
module fpsq_front
   import fpsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic signed [MAG_W-1:0] in_value,
   output logic                out_valid,
   output fpsq_stage_type      out_stage
);

   logic           valid_ff;
   logic           valid_in;
   fpsq_stage_type stage_ff;
   fpsq_stage_type stage_in;

   // The two's complement negation of the most negative value yields 2^63 as an unsigned word.
   always_comb begin
      stage_in.neg  = in_value[MAG_W-1];
      stage_in.mag  = in_value[MAG_W-1] ? (~in_value + 1'b1) : in_value;
      stage_in.rem  = '0;
      stage_in.root = '0;
      valid_in      = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

>>> hw/rtl/fpsq_step.sv
module fpsq_step
   import fpsq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  fpsq_stage_type in_stage,
   output logic           out_valid,
   output fpsq_stage_type out_stage
);

   logic           valid_ff;
   fpsq_stage_type stage_ff;
   fpsq_stage_type stage_in;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             fits;

   // One restoring step: bring down the next radicand bit pair and try to subtract 4*root+1.
   always_comb begin
      rem_shift = {in_stage.rem[REM_W-3:0], in_stage.mag[MAG_W-1 -: 2]};
      trial     = {1'b0, in_stage.root, 2'b01};
      fits      = (rem_shift >= trial);

      stage_in.neg  = in_stage.neg;
      stage_in.mag  = {in_stage.mag[MAG_W-3:0], 2'b00};
      stage_in.rem  = fits ? (rem_shift - trial) : rem_shift;
      stage_in.root = {in_stage.root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   // The remainder never exceeds twice the partial root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (stage_ff.rem <= {2'b00, stage_ff.root, 1'b0}))
      else $error("remainder out of bound");

endmodule

>>> hw/rtl/fpsq_back.sv
module fpsq_back
   import fpsq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    round_enable,
   input  logic                    in_valid,
   input  fpsq_stage_type          in_stage,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_root
);

   logic             rnd_valid_ff;
   logic             rnd_neg_ff;
   logic [OUT_W-1:0] rnd_root_ff;
   logic [OUT_W-1:0] rnd_root_in;
   logic             out_valid_ff;
   logic [OUT_W-1:0] out_root_ff;
   logic [OUT_W-1:0] out_root_in;

   // Round to nearest when round_enable is set and the final remainder exceeds the root; negate for a negative operand.
   always_comb begin
      if (round_enable && (in_stage.rem > {{(REM_W-ROOT_W){1'b0}}, in_stage.root})) begin
         rnd_root_in = {1'b0, in_stage.root} + 1'b1;
      end else begin
         rnd_root_in = {1'b0, in_stage.root};
      end
      out_root_in = rnd_neg_ff ? (~rnd_root_ff + 1'b1) : rnd_root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         rnd_valid_ff <= in_valid;
         out_valid_ff <= rnd_valid_ff;
      end
      if (advance) begin
         rnd_neg_ff  <= in_stage.neg;
         rnd_root_ff <= rnd_root_in;
         out_root_ff <= out_root_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_root_ff;

   // A rounded magnitude always fits below the sign bit.
   a_mag_fits: assert property (@(posedge clock) disable iff (reset)
      rnd_valid_ff |-> !rnd_root_ff[OUT_W-1])
      else $error("rounded root overflows");

   // A non-negative operand never gives a negative root.
   a_sign: assert property (@(posedge clock) disable iff (reset)
      (advance && rnd_valid_ff && !rnd_neg_ff) |=> !out_root_ff[OUT_W-1])
      else $error("root sign wrong for non-negative operand");

endmodule

>>> verif/fixed_point_square_root_q32_32_checker.sv
`timescale 1ns / 1ps

module fixed_point_square_root_q32_32_checker
   import fpsq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [MAG_W-1:0] req_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_root,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic                    csr_round_enable,
   output int unsigned             fail_count,
   output int unsigned             roots_pending
);

   // Shadow of the rounding control, tracked from csr transfers.
   logic             rounding;
   logic [OUT_W-1:0] roots_due[$];

   // Restoring digit-by-digit root of |operand| * 2^32, two radicand bits per step.
   function automatic logic [OUT_W-1:0] square_root_of(input logic [MAG_W-1:0] operand,
                                                       input logic round_up);
      logic [MAG_W-1:0]    magnitude;
      logic [MAG_W+31:0]   radicand;
      logic [63:0]         remainder;
      logic [63:0]         partial;
      logic [63:0]         trial;
      logic [OUT_W-1:0]    result;
      int                  step;
      magnitude = operand[MAG_W-1] ? -operand : operand;
      radicand  = {magnitude, 32'd0};
      remainder = '0;
      partial   = '0;
      for (step = ROOT_W - 1; step >= 0; step--) begin
         remainder = {remainder[61:0], radicand[2*step +: 2]};
         trial     = {partial[61:0], 2'b01};
         if (remainder >= trial) begin
            remainder = remainder - trial;
            partial   = {partial[62:0], 1'b1};
         end else begin
            partial   = {partial[62:0], 1'b0};
         end
      end
      if (round_up && remainder > partial)
         partial = partial + 64'd1;
      result = partial[OUT_W-1:0];
      return operand[MAG_W-1] ? -result : result;
   endfunction

   always @(posedge clock) begin
      logic [OUT_W-1:0] expected;
      if (reset) begin
         rounding      <= 1'b1;
         roots_due.delete();
         roots_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (roots_due.size() == 0) begin
               $error("rsp_root: expected nothing, actual %0d", rsp_root);
               fail_count <= fail_count + 1;
            end else begin
               expected = roots_due.pop_front();
               if (rsp_root !== expected) begin
                  $error("rsp_root: expected %0d, actual %0d",
                         $signed(expected), rsp_root);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            roots_due.push_back(square_root_of(req_value, rounding));
         if (csr_valid && csr_ready)
            rounding <= csr_round_enable;
         roots_pending <= roots_due.size();
      end
   end

endmodule

>>> verif/fixed_point_square_root_q32_32_test.sv
`timescale 1ns / 1ps

module fixed_point_square_root_q32_32_test;
   import fpsq_pkg::*;

   // The block is 51 stages deep; the drain wait is sized from this depth.
   localparam int unsigned PIPE_DEPTH   = 51;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned CORNER_COUNT = 13;
   localparam int unsigned RANDOM_PHASES = 4;
   localparam int unsigned PHASE_ITEMS  = 150;

   // Every input of the block holds a known value from time zero.
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic signed [MAG_W-1:0] req_value        = '0;
   logic                    rsp_stall        = 1'b0;
   logic                    csr_valid        = 1'b0;
   logic                    csr_round_enable = 1'b0;

   logic                    req_stall;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_root;
   logic                    csr_ready;

   int unsigned fail_count;
   int unsigned roots_pending;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   logic        rsp_fired   = 1'b0;
   // While this is set both sides run flat out, with no idle cycles at all.
   logic        no_idle     = 1'b0;

   always #10 clock = ~clock;

   fixed_point_square_root_q32_32 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_root         (rsp_root),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_round_enable (csr_round_enable)
   );

   fixed_point_square_root_q32_32_checker root_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_root         (rsp_root),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_round_enable (csr_round_enable),
      .fail_count       (fail_count),
      .roots_pending    (roots_pending)
   );

   // Number of idle cycles a side spends before its next transfer.
   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   // Corner operands: zero, the smallest and largest magnitudes of either sign, the most
   // negative code, exact squares such as 1.0, 4.0 and 0.25, and all-ones fractions.
   function automatic logic [MAG_W-1:0] corner_operand(input int unsigned idx);
      case (idx)
         0:       return 64'h0000_0000_0000_0000;
         1:       return 64'h0000_0000_0000_0001;
         2:       return 64'hFFFF_FFFF_FFFF_FFFF;
         3:       return 64'h7FFF_FFFF_FFFF_FFFF;
         4:       return 64'h8000_0000_0000_0000;
         5:       return 64'h8000_0000_0000_0001;
         6:       return 64'h0000_0001_0000_0000;
         7:       return 64'hFFFF_FFFF_0000_0000;
         8:       return 64'h0000_0004_0000_0000;
         9:       return 64'h0000_0000_4000_0000;
         10:      return 64'hFFFF_FFF0_0000_0000;
         11:      return 64'h0000_0000_FFFF_FFFF;
         default: return 64'h0000_0000_8000_0000;
      endcase
   endfunction

   // Random operands are a mix of full-width noise, short magnitudes, values that sit
   // right at a rounding boundary, and values near the top of the range.
   function automatic logic [MAG_W-1:0] pick_operand();
      logic [MAG_W-1:0] operand;
      logic [127:0]     boundary;
      logic [47:0]      root;
      int unsigned      width;
      case ($urandom_range(0, 3))
         0: operand = {$urandom, $urandom};
         1: begin
            width   = $urandom_range(1, 63);
            operand = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
         end
         2: begin
            // The root rounds up once the radicand passes root^2 + root, so land the
            // operand on either side of that point.
            width    = $urandom_range(1, 47);
            root     = 48'({$urandom, $urandom}) & ((48'd1 << width) - 48'd1);
            boundary = 128'(root) * 128'(root) + 128'(root);
            operand  = boundary[95:32] + 64'($urandom_range(0, 2)) - 64'd1;
         end
         default: operand = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 1) == 1)
         operand = -operand;
      return operand;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, with
   // req_valid still high so that a back-to-back transfer needs no extra edge.
   task automatic send_operand(input logic [MAG_W-1:0] operand);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= operand;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Writes round_enable; only called while the pipeline is empty.
   task automatic write_rounding(input logic enable);
      csr_valid        <= 1'b1;
      csr_round_enable <= enable;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops sending, waits for every outstanding root, then lets the pipeline run
   // long enough that any stray response would show up.
   task automatic drain();
      req_valid <= 1'b0;
      while (roots_pending != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 8) @(negedge clock);
   endtask

   // Receiver: after each response transfer, hold the response channel for a random
   // number of cycles.
   always @(negedge clock) begin
      if (rsp_fired)
         stall_left = draw_wait();
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Transfer detection for the receiver, and the watchdog that ends a hung run.
   always @(posedge clock) begin
      rsp_fired   <= rsp_valid && !rsp_stall && !reset;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned item;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // The corner operands go through once with rounding and once truncating.
      for (phase = 0; phase < 2; phase++) begin
         write_rounding(phase == 0);
         for (item = 0; item < CORNER_COUNT; item++)
            send_operand(corner_operand(item));
         drain();
      end

      // Random phases alternate the rounding mode. Every phase ends with a full drain,
      // so the sender pauses until all roots are back before the next write.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_rounding(phase[0] == 1'b0);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if ($urandom_range(0, 31) == 0)
               no_idle <= ~no_idle;
            send_operand(pick_operand());
         end
         drain();
      end

      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/fpsq_pkg.sv
hw/rtl/fpsq_front.sv
hw/rtl/fpsq_step.sv
hw/rtl/fpsq_back.sv
hw/rtl/fixed_point_square_root_q32_32.sv
verif/fixed_point_square_root_q32_32_checker.sv
verif/fixed_point_square_root_q32_32_test.sv
